### sv/ctlm_pkg.sv
// Package: shared codes and controller/datapath interface types for the task list manager
`timescale 1ns / 1ps
package ctlm_pkg;

   // Operation codes carried by req_op
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes returned on rsp_status
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_LINKED = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   // Fixed field widths of the request and response words
   localparam int TASK_W   = 4;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 5;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;     // latch request word, start link reads
      logic commit;      // decide status, update list state, first link writes
      logic link_second; // second pair of link writes for a tail append
      logic rsp_load;    // move result into the response register
   } ctlm_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_second; // the committing op is an accepted (ST_OK) append onto a non-empty list
      logic rsp_busy;    // response register holds a word not yet taken
   } ctlm_stat_type;

endpackage

### sv/ctlm_ctrl.sv
// Controller: sequences capture, commit, link writes and response load
`timescale 1ns / 1ps
module ctlm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  rsp_stall,
   input  ctlm_pkg::ctlm_stat_type stat,
   output ctlm_pkg::ctlm_cmd_type  cmd
);
   import ctlm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Only the idle state takes a new word
   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.commit = 1'b1;
            state_in   = stat.need_second ? S_LINK : S_DONE;
         end
         S_LINK: begin
            cmd.link_second = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            // response register free, or its word leaves this edge
            if (!(stat.rsp_busy && rsp_stall)) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/ctlm_datapath.sv
// Datapath: link memories, membership bits, head, count and response register
`timescale 1ns / 1ps
module ctlm_datapath #(
   parameter int MAX_TASKS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_op,
   input  logic [ctlm_pkg::TASK_W-1:0]        req_task_index,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [ctlm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ctlm_pkg::TASK_W-1:0]        rsp_head_index,
   output logic [ctlm_pkg::SIZE_W-1:0]        rsp_size,
   input  ctlm_pkg::ctlm_cmd_type             cmd,
   output ctlm_pkg::ctlm_stat_type            stat
);
   import ctlm_pkg::*;

   // Only slots a task_index can reach are kept
   localparam int SLOTS = (MAX_TASKS < (1 << TASK_W)) ? MAX_TASKS : (1 << TASK_W);
   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);

   // Link memories, one write and one registered read each per cycle
   logic [SW-1:0] next_mem [SLOTS];
   logic [SW-1:0] prev_mem [SLOTS];
   logic [SW-1:0] next_rd_ff;
   logic [SW-1:0] prev_rd_ff;
   logic [SW-1:0] next_ra;
   logic [SW-1:0] prev_ra;
   logic          next_we;
   logic [SW-1:0] next_wa;
   logic [SW-1:0] next_wd;
   logic          prev_we;
   logic [SW-1:0] prev_wa;
   logic [SW-1:0] prev_wd;

   // List state
   logic [SLOTS-1:0] linked_ff;
   logic [SLOTS-1:0] linked_in;
   logic [SW-1:0]    head_ff;
   logic [SW-1:0]    head_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   // Captured request word
   logic              op_ff;
   logic [TASK_W-1:0] task_ff;

   // Result held between commit and response load
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   // Response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TASK_W-1:0]   rsp_head_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;

   // Decode of the captured word
   logic          in_range;
   logic [SW-1:0] slot;
   logic          flag_hit;
   logic          count_zero;
   logic          count_one;
   logic          op_ok;

   assign slot       = task_ff[SW-1:0];
   assign in_range   = (32'(task_ff) < 32'(MAX_TASKS));
   assign flag_hit   = in_range && linked_ff[slot];
   assign count_zero = (count_ff == '0);
   assign count_one  = (count_ff == CW'(1));

   always_comb begin
      if (op_ff == OP_APPEND) begin
         if (!in_range) begin
            status_in = ST_ABSENT;
         end else if (flag_hit) begin
            status_in = ST_LINKED;
         end else begin
            status_in = ST_OK;
         end
      end else begin
         if (count_zero) begin
            status_in = ST_EMPTY;
         end else if (!flag_hit) begin
            status_in = ST_ABSENT;
         end else begin
            status_in = ST_OK;
         end
      end
   end

   assign op_ok = (status_in == ST_OK);

   assign stat.need_second = op_ok && (op_ff == OP_APPEND) && !count_zero;
   assign stat.rsp_busy    = rsp_valid_ff;

   // Read addresses: remove reads both links of the slot, append reads the tail via head
   assign next_ra = req_task_index[SW-1:0];
   assign prev_ra = (req_op == OP_REMOVE) ? req_task_index[SW-1:0] : head_ff;

   // State update and link write selection
   always_comb begin
      linked_in = linked_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      next_we   = 1'b0;
      next_wa   = slot;
      next_wd   = slot;
      prev_we   = 1'b0;
      prev_wa   = slot;
      prev_wd   = slot;
      if (cmd.commit && op_ok) begin
         if (op_ff == OP_APPEND) begin
            linked_in[slot] = 1'b1;
            count_in        = count_ff + CW'(1);
            next_we         = 1'b1;
            prev_we         = 1'b1;
            if (count_zero) begin
               // lone slot points at itself
               head_in = slot;
            end else begin
               // tail.next = t, t.prev = tail
               next_wa = prev_rd_ff;
               prev_wd = prev_rd_ff;
            end
         end else begin
            linked_in[slot] = 1'b0;
            count_in        = count_ff - CW'(1);
            if (count_one) begin
               head_in = '0;
            end else begin
               if (head_ff == slot) begin
                  head_in = next_rd_ff;
               end
               // pv.next = nx, nx.prev = pv
               next_we = 1'b1;
               next_wa = prev_rd_ff;
               next_wd = next_rd_ff;
               prev_we = 1'b1;
               prev_wa = next_rd_ff;
               prev_wd = prev_rd_ff;
            end
         end
      end else if (cmd.link_second) begin
         // t.next = head, head.prev = t
         next_we = 1'b1;
         next_wd = head_ff;
         prev_we = 1'b1;
         prev_wa = head_ff;
      end
   end

   // Link memories
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (cmd.capture) begin
         next_rd_ff <= next_mem[next_ra];
         prev_rd_ff <= prev_mem[prev_ra];
      end
   end

   // Response register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff    <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         linked_ff    <= linked_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         task_ff <= req_task_index;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_head_ff   <= TASK_W'(head_ff);
         rsp_size_ff   <= SIZE_W'(count_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_index = rsp_head_ff;
   assign rsp_size       = rsp_size_ff;

endmodule

### sv/circular_task_list_manager_core.sv
// Sequence per request: capture on accept, commit, a second link write step for an append onto a
//   non-empty list (the single write port on each link memory forces it), then response load.
//   A new request is not taken until the previous one has been loaded into the response register.
// A finished word waits in the response register while the next request is taken.
// Reset (synchronous, active high) empties the list: membership bits, head and count clear;
//   link memories are not cleared and their contents are only used for linked slots.
`timescale 1ns / 1ps
module circular_task_list_manager_core #(
   parameter int MAX_TASKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [ctlm_pkg::TASK_W-1:0]   req_task_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ctlm_pkg::STATUS_W-1:0] rsp_status,
   output logic [ctlm_pkg::TASK_W-1:0]   rsp_head_index,
   output logic [ctlm_pkg::SIZE_W-1:0]   rsp_size
);
   import ctlm_pkg::*;

   ctlm_cmd_type  cmd;
   ctlm_stat_type stat;

   // Sequencer
   ctlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // List storage and response
   ctlm_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_task_index (req_task_index),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_head_index (rsp_head_index),
      .rsp_size       (rsp_size),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

### bench/circular_task_list_manager_core_tb.sv
// Self-checking bench for the circular task list manager: directed rows, then random list churn
`timescale 1ns / 1ps
module circular_task_list_manager_core_tb;
   import ctlm_pkg::*;

   localparam int SLOTS         = 16;
   localparam int RANDOM_WORDS  = 1330;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;

   // one result word as the block reports it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   head;
      logic [SIZE_W-1:0]   size;
   } list_result_type;

   // one directed row; typed rows carry a hand-written result
   typedef struct packed {
      logic         op;
      logic [TASK_W-1:0] idx;
      logic         typed;
      list_result_type res;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = OP_APPEND;
   logic [TASK_W-1:0]   req_task_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [TASK_W-1:0]   rsp_head_index;
   logic [SIZE_W-1:0]   rsp_size;

   // shadow copy of the link table
   logic [TASK_W-1:0] slot_next [SLOTS];
   logic [TASK_W-1:0] slot_prev [SLOTS];
   logic              slot_member [SLOTS];
   logic [TASK_W-1:0] list_head;
   logic [SIZE_W-1:0] list_count;

   list_result_type pending_results [$];
   stim_row_type    stim_rows [$];

   int unsigned error_count = 0;
   int unsigned words_checked = 0;
   int unsigned append_count = 0;
   int unsigned remove_count = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   int unsigned peak_size = 0;
   int unsigned burst_left = 0;
   int unsigned rsp_cycle = 0;
   int unsigned stall_mode = 0;

   circular_task_list_manager_core #(.MAX_TASKS(SLOTS)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_task_index (req_task_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_head_index (rsp_head_index),
      .rsp_size       (rsp_size)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // reset asserted from the start, then released once
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // safety net
   initial begin
      #400000;
      $display("circular_task_list_manager_core verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("MISMATCH word %0d %s: expected %0d, got %0d", words_checked, what, want, got);
      error_count++;
   endtask

   // apply one append/remove to the shadow list and return the word it should yield
   function automatic list_result_type apply_list_op(input logic op,
                                                     input logic [TASK_W-1:0] t);
      list_result_type   r;
      logic [TASK_W-1:0] tail, nx, pv;
      r.status = ST_OK;
      if (op == OP_APPEND) begin
         if (slot_member[t]) begin
            r.status = ST_LINKED;
         end else begin
            if (list_count == 0) begin
               list_head    = t;
               slot_next[t] = t;
               slot_prev[t] = t;
            end else begin
               tail               = slot_prev[list_head];
               slot_next[tail]    = t;
               slot_prev[t]       = tail;
               slot_next[t]       = list_head;
               slot_prev[list_head] = t;
            end
            slot_member[t] = 1'b1;
            list_count++;
         end
      end else begin
         if (list_count == 0) begin
            r.status = ST_EMPTY;
         end else if (!slot_member[t]) begin
            r.status = ST_ABSENT;
         end else begin
            if (list_count == 1) begin
               list_head = '0;
            end else begin
               nx = slot_next[t];
               pv = slot_prev[t];
               if (list_head == t) list_head = nx;
               slot_next[pv] = nx;
               slot_prev[nx] = pv;
            end
            slot_member[t] = 1'b0;
            list_count--;
         end
      end
      r.head = (list_count == 0) ? '0 : list_head;
      r.size = list_count;
      return r;
   endfunction

   // random slot that is (or is not) on the list; any slot if none qualifies
   function automatic logic [TASK_W-1:0] pick_slot(input logic want_linked);
      int unsigned       hits, k, n;
      logic [TASK_W-1:0] chosen;
      hits = 0;
      for (int i = 0; i < SLOTS; i++) if (slot_member[i] == want_linked) hits++;
      if (hits == 0) return TASK_W'($urandom_range(0, SLOTS - 1));
      k      = $urandom_range(0, hits - 1);
      n      = 0;
      chosen = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_member[i] == want_linked) begin
            if (n == k) chosen = TASK_W'(i);
            n++;
         end
      end
      return chosen;
   endfunction

   task automatic add_row(input logic op, input logic [TASK_W-1:0] idx, input logic typed,
                          input logic [STATUS_W-1:0] st, input logic [TASK_W-1:0] hd,
                          input logic [SIZE_W-1:0] sz);
      stim_row_type row;
      row.op         = op;
      row.idx        = idx;
      row.typed      = typed;
      row.res.status = st;
      row.res.head   = hd;
      row.res.size   = sz;
      stim_rows.push_back(row);
   endtask

   // offer one word in bursts with random gaps; queue its result on acceptance
   task automatic send_word(input logic op, input logic [TASK_W-1:0] idx, input logic typed,
                            input list_result_type typed_res);
      list_result_type predicted;
      int unsigned     gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_task_index <= idx;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_op(op, idx);
      pending_results.push_back(typed ? typed_res : predicted);
      if (op == OP_APPEND) append_count++;
      else remove_count++;
      burst_left--;
   endtask

   // hold the sender until every queued result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      burst_left = 0;
   endtask

   // stimulus
   initial begin
      list_result_type none;
      logic         op;
      logic [TASK_W-1:0] idx;
      int unsigned  phase;
      int unsigned  drain_cycles;

      none = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_next[i]   = '0;
         slot_prev[i]   = '0;
         slot_member[i] = 1'b0;
      end
      list_head  = '0;
      list_count = '0;

      // removes on an empty list, duplicate append, unknown slot, last slot out
      add_row(OP_REMOVE, 4'd0,  1'b1, ST_EMPTY,  4'd0,  5'd0);
      add_row(OP_REMOVE, 4'd15, 1'b1, ST_EMPTY,  4'd0,  5'd0);
      add_row(OP_APPEND, 4'd15, 1'b1, ST_OK,     4'd15, 5'd1);
      add_row(OP_APPEND, 4'd15, 1'b1, ST_LINKED, 4'd15, 5'd1);
      add_row(OP_REMOVE, 4'd0,  1'b1, ST_ABSENT, 4'd15, 5'd1);
      add_row(OP_REMOVE, 4'd15, 1'b1, ST_OK,     4'd0,  5'd0);
      add_row(OP_APPEND, 4'd0,  1'b1, ST_OK,     4'd0,  5'd1);
      // build a short ring, then take out head, middle and tail
      add_row(OP_APPEND, 4'd5,  1'b0, ST_OK, '0, '0);
      add_row(OP_APPEND, 4'd10, 1'b0, ST_OK, '0, '0);
      add_row(OP_APPEND, 4'd15, 1'b0, ST_OK, '0, '0);
      add_row(OP_REMOVE, 4'd0,  1'b0, ST_OK, '0, '0);
      add_row(OP_REMOVE, 4'd10, 1'b0, ST_OK, '0, '0);
      add_row(OP_APPEND, 4'd0,  1'b0, ST_OK, '0, '0);
      add_row(OP_REMOVE, 4'd0,  1'b0, ST_OK, '0, '0);
      add_row(OP_APPEND, 4'd10, 1'b0, ST_OK, '0, '0);
      add_row(OP_REMOVE, 4'd5,  1'b0, ST_OK, '0, '0);
      add_row(OP_REMOVE, 4'd15, 1'b0, ST_OK, '0, '0);
      add_row(OP_REMOVE, 4'd10, 1'b1, ST_OK,     4'd0,  5'd0);

      do @(posedge clock); while (reset);

      foreach (stim_rows[i]) send_word(stim_rows[i].op, stim_rows[i].idx,
                                       stim_rows[i].typed, stim_rows[i].res);
      drain_results();

      // random churn: grow, shrink and mixed phases, mostly well-formed picks
      phase = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n != 0 && n % 30 == 0) phase = $urandom_range(0, 2);
         if (n == RANDOM_WORDS / 2) drain_results();
         case (phase)
            0: op = ($urandom_range(0, 9) < 8) ? OP_APPEND : OP_REMOVE;
            1: op = ($urandom_range(0, 9) < 8) ? OP_REMOVE : OP_APPEND;
            default: op = $urandom_range(0, 1) ? OP_REMOVE : OP_APPEND;
         endcase
         if ($urandom_range(0, 99) < 85) idx = pick_slot(op == OP_REMOVE);
         else idx = TASK_W'($urandom_range(0, SLOTS - 1));
         send_word(op, idx, 1'b0, none);
      end

      // wind down
      req_valid    <= 1'b0;
      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_results.size() != 0) begin
         report_mismatch("result never arrived, size", 32'(pending_results[0].size), 0);
         void'(pending_results.pop_front());
      end

      $display("Run: %0d words sent (%0d append, %0d remove), %0d results checked, peak size %0d",
               append_count + remove_count, append_count, remove_count, words_checked,
               peak_size);
      $display("Statuses seen: ok %0d, already linked %0d, empty %0d, not in list %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("circular_task_list_manager_core verification clean");
      end else begin
         $display("circular_task_list_manager_core verification failed");
      end
      $finish;
   end

   // response stall pattern, with two long hold-offs to back the block up
   always @(posedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if ((rsp_cycle >= 1500 && rsp_cycle < 1800) || (rsp_cycle >= 6000 && rsp_cycle < 6250)) begin
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((rsp_cycle % 8) < 3);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word, size", 0, 32'(rsp_size));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_head_index !== want.head)
               report_mismatch("head", 32'(want.head), 32'(rsp_head_index));
            if (rsp_size !== want.size)
               report_mismatch("size", 32'(want.size), 32'(rsp_size));
         end
         words_checked++;
         status_seen[rsp_status]++;
         if (32'(rsp_size) > peak_size) peak_size = 32'(rsp_size);
      end
   end

endmodule
